// File: hw/rtl/lbt_pkg.sv
// ----------------------------------------------------------------------------
// lbt_pkg
// shared widths, types and helpers of the x-axis lorentz boost core
// ----------------------------------------------------------------------------
package lbt_pkg;

    localparam int COORD_W  = 32;
    localparam int VF       = 15;
    localparam int VEL_W    = VF + 1;
    localparam int VEL_LIM  = (1 << VF) - 1;
    localparam int PSHIFT   = 31;
    localparam int GAMMA_W  = 24;
    localparam int ONE2     = 1 << (2 * VF);
    localparam int DEN_W    = 2 * VF + 1;
    localparam int NUM_W    = VEL_W + 2 * VF + 1;
    localparam int NSTG     = VF + 3;

    typedef struct packed {
        logic                      ready;
        logic signed [VEL_W-1:0]   b;
        logic [GAMMA_W-1:0]        gamma;
    } lbt_frame_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] t;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      ovf;
    } lbt_coord_t;

    function automatic logic signed [VEL_W-1:0] vel_clamp(input logic signed [VEL_W-1:0] v);
        if (v < -VEL_LIM) begin
            return VEL_W'(-VEL_LIM);
        end
        return v;
    endfunction

endpackage

// File: hw/rtl/lorentz_boost_transform_core.sv
// ----------------------------------------------------------------------------
// lorentz_boost_transform_core
// lorentz boost along x of spacetime events with velocity composition
// ----------------------------------------------------------------------------
// One item per clock is accepted and one result item leaves per clock while
// the output does not stall and the gamma unit is idle; the velocity divider
// resolves one quotient bit per pipeline stage. Stages advance on their own, so
// a stalled output only holds the stages that are full. After a frame_velocity
// write the serial gamma unit runs one square, 63 divide steps and 32 square
// root steps; s_tready and cfg_ready stay low meanwhile.
module lorentz_boost_transform_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // event_time, event_x, event_y, event_z, object_velocity
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // boosted_time, boosted_x, boosted_y, boosted_z, boosted_velocity,
    // overflow_flag, zero fill
    output logic [151:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);
    import lbt_pkg::*;

    lbt_frame_t              frame;
    lbt_coord_t              coord;
    logic signed [VEL_W-1:0] vel;
    logic                    vel_ovf;
    logic [NSTG-1:0]         valid_reg;
    logic [NSTG-1:0]         en;
    logic [NSTG-1:0]         msk;

    lbt_gamma u_gamma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .frame     (frame)
    );

    lbt_coord u_coord (
        .aclk  (aclk),
        .en    (en),
        .frame (frame),
        .t_in  (s_tdata[COORD_W-1:0]),
        .x_in  (s_tdata[2*COORD_W-1:COORD_W]),
        .y_in  (s_tdata[3*COORD_W-1:2*COORD_W]),
        .z_in  (s_tdata[4*COORD_W-1:3*COORD_W]),
        .res   (coord)
    );

    lbt_vdiv u_vdiv (
        .aclk  (aclk),
        .en    (en),
        .frame (frame),
        .u_in  (s_tdata[4*COORD_W+VEL_W-1:4*COORD_W]),
        .vel   (vel),
        .ovf   (vel_ovf)
    );

    // a stage may load when m_tready is high or when it or any later stage holds a bubble
    always_comb begin
        msk = '0;
        for (int i = 0; i < NSTG; i++) begin
            msk   = (NSTG'(1) << i) - NSTG'(1);
            en[i] = m_tready || !(&(valid_reg | msk));
        end
    end

    assign s_tready = en[0] && frame.ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid && s_tready;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = {7'b0, coord.ovf | vel_ovf, vel, coord.z, coord.y, coord.x, coord.t};

    a_no_item_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame.ready |-> !s_tready)
        else $error("item accepted while gamma unit busy");

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_tready)
        else $error("input open right after frame velocity write");

    a_vel_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[143:128] != 16'h8000))
        else $error("boosted velocity outside saturation range");

endmodule

// File: hw/rtl/lbt_gamma.sv
// ----------------------------------------------------------------------------
// lbt_gamma
// frame velocity register and serial gamma unit (divide, then square root)
// ----------------------------------------------------------------------------
module lbt_gamma (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic signed [lbt_pkg::VEL_W-1:0] cfg_data,
    output lbt_pkg::lbt_frame_t              frame
);
    import lbt_pkg::*;

    localparam int QUO_W      = 2 * PSHIFT + 1;
    localparam int DIV_STEPS  = QUO_W;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int GAMMA_ONE  = 1 << (PSHIFT - VF);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_ROOT   = 4'b1000
    } gstate_t;

    gstate_t                  state_reg, state_next;
    logic signed [VEL_W-1:0]  b_reg, b_next;
    logic [GAMMA_W-1:0]       gamma_reg, gamma_next;
    logic [DEN_W-1:0]         d_reg, d_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [RAD_W-1:0]         rad_reg, rad_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [SREM_W-1:0]        srem_reg, srem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic signed [2*VEL_W-1:0] sq;
    logic [DEN_W:0]            rem_sh;
    logic                      qbit;
    logic [SREM_W+1:0]         s_sh;
    logic [SREM_W+1:0]         s_trial;

    always_comb begin
        state_next = state_reg;
        b_next     = b_reg;
        gamma_next = gamma_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        cnt_next   = cnt_reg;
        sq         = b_reg * b_reg;
        rem_sh     = {rem_reg, cnt_reg == '0};
        qbit       = rem_sh >= {1'b0, d_reg};
        s_sh       = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        s_trial    = (SREM_W + 2)'({root_reg, 2'b01});
        case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    b_next     = vel_clamp(cfg_data);
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                d_next     = DEN_W'(ONE2 - int'(sq));
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                rem_next = qbit ? DEN_W'(rem_sh - {1'b0, d_reg}) : DEN_W'(rem_sh);
                quo_next = {quo_reg[QUO_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    rad_next   = RAD_W'(quo_next);
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (s_sh >= s_trial) begin
                    srem_next = SREM_W'(s_sh - s_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    srem_next = SREM_W'(s_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1)) begin
                    gamma_next = GAMMA_W'(root_next);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            b_reg     <= '0;
            gamma_reg <= GAMMA_W'(GAMMA_ONE);
        end else begin
            state_reg <= state_next;
            b_reg     <= b_next;
            gamma_reg <= gamma_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        cnt_reg  <= cnt_next;
    end

    assign cfg_ready   = (state_reg == ST_IDLE);
    assign frame.ready = (state_reg == ST_IDLE);
    assign frame.b     = b_reg;
    assign frame.gamma = gamma_reg;

endmodule

// File: hw/rtl/lbt_coord.sv
// ----------------------------------------------------------------------------
// lbt_coord
// pipelined t' and x' boost with rounding and saturation, y and z carried
// ----------------------------------------------------------------------------
module lbt_coord (
    input  logic                               aclk,
    input  logic [lbt_pkg::NSTG-1:0]           en,
    input  lbt_pkg::lbt_frame_t                frame,
    input  logic signed [lbt_pkg::COORD_W-1:0] t_in,
    input  logic signed [lbt_pkg::COORD_W-1:0] x_in,
    input  logic signed [lbt_pkg::COORD_W-1:0] y_in,
    input  logic signed [lbt_pkg::COORD_W-1:0] z_in,
    output lbt_pkg::lbt_coord_t                res
);
    import lbt_pkg::*;

    localparam int PB_W   = VEL_W + COORD_W;
    localparam int N_W    = COORD_W + VF + 2;
    localparam int M_W    = N_W - 1;
    localparam int HALF_W = M_W / 2;
    localparam int PH_W   = HALF_W + GAMMA_W;
    localparam int PROD_W = M_W + GAMMA_W;
    localparam int MAG_W  = PROD_W - PSHIFT + 1;
    localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    function automatic logic [COORD_W:0] boost_fin(input logic [PH_W-1:0] lo,
                                                   input logic [PH_W-1:0] hi,
                                                   input logic neg);
        logic [PROD_W-1:0] p;
        logic [MAG_W-1:0]  mag;
        p   = (PROD_W'(hi) << HALF_W) + PROD_W'(lo);
        mag = MAG_W'(p[PROD_W-1:PSHIFT]) + MAG_W'(p[PSHIFT-1]);
        if (!neg && mag > MAG_LIM) begin
            return {1'b1, C_MAX};
        end
        if (neg && mag > MAG_LIM + 1'b1) begin
            return {1'b1, C_MIN};
        end
        return {1'b0, neg ? COORD_W'(-mag) : COORD_W'(mag)};
    endfunction

    // stage 0: cross products
    logic signed [COORD_W-1:0] t0_reg, x0_reg, y0_reg, z0_reg;
    logic signed [PB_W-1:0]    bx0_reg, bt0_reg;
    // stage 1: numerator magnitude
    logic [M_W-1:0]            mt1_reg, mx1_reg;
    logic                      nt1_reg, nx1_reg;
    logic signed [COORD_W-1:0] y1_reg, z1_reg;
    // stage 2: partial products with gamma
    logic [PH_W-1:0]           tlo2_reg, thi2_reg, xlo2_reg, xhi2_reg;
    logic                      nt2_reg, nx2_reg;
    logic signed [COORD_W-1:0] y2_reg, z2_reg;
    // stage 3 onward: results
    lbt_coord_t                pipe_reg [3:NSTG-1];

    logic signed [N_W-1:0] nt, nx;
    logic [COORD_W:0]      fin_t, fin_x;

    always_comb begin
        nt    = (N_W'(t0_reg) <<< VF) - N_W'(bx0_reg);
        nx    = (N_W'(x0_reg) <<< VF) - N_W'(bt0_reg);
        fin_t = boost_fin(tlo2_reg, thi2_reg, nt2_reg);
        fin_x = boost_fin(xlo2_reg, xhi2_reg, nx2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t0_reg  <= t_in;
            x0_reg  <= x_in;
            y0_reg  <= y_in;
            z0_reg  <= z_in;
            bx0_reg <= frame.b * x_in;
            bt0_reg <= frame.b * t_in;
        end
        if (en[1]) begin
            nt1_reg <= nt[N_W-1];
            nx1_reg <= nx[N_W-1];
            mt1_reg <= M_W'(nt[N_W-1] ? -nt : nt);
            mx1_reg <= M_W'(nx[N_W-1] ? -nx : nx);
            y1_reg  <= y0_reg;
            z1_reg  <= z0_reg;
        end
        if (en[2]) begin
            tlo2_reg <= PH_W'(mt1_reg[HALF_W-1:0]) * PH_W'(frame.gamma);
            thi2_reg <= PH_W'(mt1_reg[M_W-1:HALF_W]) * PH_W'(frame.gamma);
            xlo2_reg <= PH_W'(mx1_reg[HALF_W-1:0]) * PH_W'(frame.gamma);
            xhi2_reg <= PH_W'(mx1_reg[M_W-1:HALF_W]) * PH_W'(frame.gamma);
            nt2_reg  <= nt1_reg;
            nx2_reg  <= nx1_reg;
            y2_reg   <= y1_reg;
            z2_reg   <= z1_reg;
        end
        if (en[3]) begin
            pipe_reg[3].t   <= fin_t[COORD_W-1:0];
            pipe_reg[3].x   <= fin_x[COORD_W-1:0];
            pipe_reg[3].y   <= y2_reg;
            pipe_reg[3].z   <= z2_reg;
            pipe_reg[3].ovf <= fin_t[COORD_W] | fin_x[COORD_W];
        end
        for (int i = 4; i < NSTG; i++) begin
            if (en[i]) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign res = pipe_reg[NSTG-1];

endmodule

// File: hw/rtl/lbt_vdiv.sv
// ----------------------------------------------------------------------------
// lbt_vdiv
// pipelined relativistic velocity composition (u-b)/(1-ub), one quotient
// bit per stage
// ----------------------------------------------------------------------------
module lbt_vdiv (
    input  logic                             aclk,
    input  logic [lbt_pkg::NSTG-1:0]         en,
    input  lbt_pkg::lbt_frame_t              frame,
    input  logic signed [lbt_pkg::VEL_W-1:0] u_in,
    output logic signed [lbt_pkg::VEL_W-1:0] vel,
    output logic                             ovf
);
    import lbt_pkg::*;

    localparam logic [VEL_W-1:0] LIM_V = VEL_W'(VEL_LIM);

    logic signed [2*VEL_W-1:0] ub0_reg;
    logic signed [VEL_W:0]     diff0_reg;
    logic [NUM_W-1:0]          n1_reg;
    logic [DEN_W-1:0]          den1_reg;
    logic                      neg1_reg;
    logic [NUM_W-1:0]          rem_reg  [2:NSTG-2];
    logic [DEN_W-1:0]          den_reg  [2:NSTG-2];
    logic                      neg_reg  [2:NSTG-2];
    logic                      sat_reg  [2:NSTG-2];
    logic [VF-1:0]             q_reg    [2:NSTG-2];
    logic signed [VEL_W-1:0]   vel_reg;
    logic                      ovf_reg;

    logic signed [VEL_W-1:0]   u_c;
    logic [DEN_W-1:0]          den;
    logic [VEL_W-1:0]          dmag;
    logic [NUM_W-1:0]          sh;
    logic                      take;
    logic [NUM_W-1:0]          step_rem [3:NSTG-1];
    logic [VF-1:0]             step_q   [3:NSTG-1];
    logic [VEL_W-1:0]          qv;

    always_comb begin
        u_c  = vel_clamp(u_in);
        den  = DEN_W'(ONE2 - int'(ub0_reg));
        dmag = VEL_W'(diff0_reg < 0 ? -diff0_reg : diff0_reg);
        sh   = '0;
        take = 1'b0;
        for (int k = 3; k < NSTG; k++) begin
            sh          = NUM_W'(den_reg[k-1]) << (NSTG - 1 - k);
            take        = rem_reg[k-1] >= sh;
            step_rem[k] = take ? rem_reg[k-1] - sh : rem_reg[k-1];
            step_q[k]   = q_reg[k-1] | (VF'(take) << (NSTG - 1 - k));
        end
        qv = {1'b0, step_q[NSTG-1]};
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ub0_reg   <= u_c * frame.b;
            diff0_reg <= (VEL_W + 1)'(u_c) - (VEL_W + 1)'(frame.b);
        end
        if (en[1]) begin
            n1_reg   <= (NUM_W'(dmag) << (2 * VF)) + NUM_W'(den >> 1);
            den1_reg <= den;
            neg1_reg <= diff0_reg < 0;
        end
        if (en[2]) begin
            rem_reg[2] <= n1_reg;
            den_reg[2] <= den1_reg;
            neg_reg[2] <= neg1_reg;
            sat_reg[2] <= n1_reg >= (NUM_W'(den1_reg) << VF);
            q_reg[2]   <= '0;
        end
        for (int k = 3; k < NSTG - 1; k++) begin
            if (en[k]) begin
                rem_reg[k] <= step_rem[k];
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                q_reg[k]   <= step_q[k];
            end
        end
        if (en[NSTG-1]) begin
            if (sat_reg[NSTG-2]) begin
                vel_reg <= neg_reg[NSTG-2] ? -LIM_V : LIM_V;
            end else begin
                vel_reg <= neg_reg[NSTG-2] ? -qv : qv;
            end
            ovf_reg <= sat_reg[NSTG-2];
        end
    end

    assign vel = vel_reg;
    assign ovf = ovf_reg;

endmodule

// File: test/lorentz_boost_checker.sv
// ----------------------------------------------------------------------------
// lorentz_boost_checker
// watches the config, event and result channels of the boost core, predicts
// each boosted event in fixed point and compares it field by field in order
// ----------------------------------------------------------------------------
module lorentz_boost_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [151:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    output int           error_count,
    output int           pending_count,
    output int           result_count,
    output int           overflow_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import lbt_pkg::*;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] vel;
        logic        ovf;
    } boosted_event_t;

    boosted_event_t boosted_queue[$];
    logic [15:0]    frame_vel;

    function automatic longint clamp_velocity(input logic [15:0] raw);
        longint s;
        s = longint'($signed(raw));
        if (s > VEL_LIM) s = VEL_LIM;
        if (s < -VEL_LIM) s = -VEL_LIM;
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned gamma_for(input longint b);
        longint unsigned d;
        d = (64'd1 << (2 * VF)) - longint'(b * b);
        if (d == 0) d = 1;
        return int_sqrt((64'd1 << 62) / d);
    endfunction

    // gamma * (a - b*c), saturated to 32 bits
    function automatic logic [31:0] boost_coord(input logic [31:0] a32, input logic [31:0] c32,
                                                input longint b, input longint unsigned g,
                                                inout logic ovf);
        longint unsigned a, c, n, m, plo, phi, mag;
        longint unsigned limpos;
        logic neg;
        a = {{32{a32[31]}}, a32};
        c = {{32{c32[31]}}, c32};
        n = (a << VF) - longint'(b) * c;
        neg = n[63];
        m = neg ? -n : n;
        plo = (m & 64'hFFFF_FFFF) * g;
        phi = (m >> 32) * g;
        limpos = 64'h7FFF_FFFF;
        if (phi > (64'd1 << 61)) mag = '1;
        else mag = (phi << (32 - PSHIFT)) + (plo >> PSHIFT) + ((plo >> (PSHIFT - 1)) & 1);
        if (!neg && mag > limpos) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (neg && mag > limpos + 1) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        mag = neg ? -mag : mag;
        return mag[31:0];
    endfunction

    function automatic logic [15:0] compose_velocity(input longint u, input longint b,
                                                     inout logic ovf);
        longint diff;
        longint unsigned num, den, q;
        logic neg;
        diff = u - b;
        neg = diff < 0;
        num = longint'(neg ? -diff : diff) << (2 * VF);
        den = (64'd1 << (2 * VF)) - longint'(u * b);
        if (den == 0) den = 1;
        q = (num + den / 2) / den;
        if (q > VEL_LIM) begin
            q = VEL_LIM;
            ovf = 1'b1;
        end
        q = neg ? -q : q;
        return q[15:0];
    endfunction

    function automatic boosted_event_t boost_event(input logic [143:0] d, input logic [15:0] fv);
        boosted_event_t r;
        longint b, u;
        longint unsigned g;
        logic ovf;
        ovf = 1'b0;
        b = clamp_velocity(fv);
        u = clamp_velocity(d[143:128]);
        g = gamma_for(b);
        r.t = boost_coord(d[31:0], d[63:32], b, g, ovf);
        r.x = boost_coord(d[63:32], d[31:0], b, g, ovf);
        r.y = d[95:64];
        r.z = d[127:96];
        r.vel = compose_velocity(u, b, ovf);
        r.ovf = ovf;
        return r;
    endfunction

    assign pending_count = boosted_queue.size();

    always @(posedge aclk) begin
        boosted_event_t want, got;
        if (!aresetn) begin
            frame_vel <= '0;
            error_count <= 0;
            result_count <= 0;
            overflow_count <= 0;
            boosted_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready) frame_vel <= cfg_data;
            if (s_tvalid && s_tready) begin
                boosted_queue.insert(boosted_queue.size(), boost_event(s_tdata, frame_vel));
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                       m_tdata[143:128], m_tdata[144]};
                result_count <= result_count + 1;
                if (boosted_queue.size() == 0) begin
                    $display("%0t unexpected item: actual %h", $time, got);
                    error_count <= error_count + 1;
                end else begin
                    want = boosted_queue.pop_front();
                    if (want.ovf) overflow_count <= overflow_count + 1;
                    if (got !== want) begin
                        $display("%0t mismatch t/x/y/z/vel/ovf expected %h %h %h %h %h %b",
                                 $time, want.t, want.x, want.y, want.z, want.vel, want.ovf);
                        $display("%0t                         actual   %h %h %h %h %h %b",
                                 $time, got.t, got.x, got.y, got.z, got.vel, got.ovf);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the lorentz boost core: directed edge events, then
// random events over several frame velocities and idle/stall patterns
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;

    int error_count, pending_count, result_count, overflow_count;
    int send_idle_pct, recv_stall_pct;
    int hold_request, hold_seen, hold_left;
    int cycle_count;
    int phase_count;

    lorentz_boost_transform_core dut (.*);

    lorentz_boost_checker checker_i (.*);

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 300000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_request != hold_seen) begin
            hold_seen <= hold_request;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(2000)) - 1000);
            3: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_vel(input logic [15:0] fv);
        case ($urandom_range(6))
            0: return 16'h7FFF;
            1: return 16'h8001;
            2: return 16'h8000;
            3: return fv;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_event(input logic [31:0] t, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [15:0] u);
        s_tvalid <= 1'b1;
        s_tdata <= {u, z, y, x, t};
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_frame(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] frames[6];
        logic [15:0] fv;
        int n;
        frames = '{16'h7FFF, 16'h8000, 16'h0000, 16'd12345, 16'hB1E0, 16'h0000};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_request = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        phase_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset frame velocity is zero: extreme coordinates pass straight through
        send_event(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 16'h7FFF);
        send_event(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 16'h8000);
        send_event(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000);
        send_event(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 16'h8001);
        drain();
        // near light speed frame: overflow, equal velocity and clamp cases
        fv = 16'h7FFF;
        write_frame(fv);
        send_event(32'h7FFF_FFFF, 32'h0, 32'h1, 32'h2, 16'h7FFF);
        send_event(32'h0, 32'h8000_0000, 32'h3, 32'h4, 16'h8000);
        send_event(32'd1000, 32'd1000, 32'h5, 32'h6, 16'h8001);
        send_event(32'd1, 32'hFFFF_FFFF, 32'h7, 32'h8, 16'h0000);
        send_event(32'h0100_0000, 32'h0100_0000, 32'h9, 32'hA, 16'h4000);
        drain();
        fv = 16'h8000;
        write_frame(fv);
        send_event(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'h8000);
        send_event(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'h7FFF);
        send_event(32'd12345, 32'hFFFF_0000, 32'h0, 32'h0, 16'h8001);
        send_event(32'hFFFF_FFFF, 32'd1, 32'h0, 32'h0, 16'hC000);
        drain();
        fv = 16'd16384;
        write_frame(fv);
        send_event(32'd3, 32'd5, 32'h0, 32'h0, 16'd16384);
        send_event(32'hFFFF_FFFD, 32'd7, 32'h0, 32'h0, 16'h7FFF);
        send_event(32'h4000_0000, 32'hC000_0000, 32'h0, 32'h0, 16'h8000);
        send_event(32'd0, 32'd1, 32'h0, 32'h0, 16'hC000);
        drain();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 14 : (p < 4) ? 83 : 0;
            recv_stall_pct = (p < 2) ? 83 : (p < 4) ? 14 : 0;
            fv = (p == 5) ? 16'($urandom) : frames[p];
            write_frame(fv);
            n = 0;
            while (n < 285) begin
                if (p == 4 && n == 20) hold_request = hold_request + 1;
                send_event(rand_coord(), rand_coord(), $urandom, $urandom, rand_vel(fv));
                n++;
            end
            drain();
            phase_count++;
        end

        $display("covered %0d boosted events over %0d random phases, %0d with overflow",
                 result_count, phase_count, overflow_count);
        $display("frame velocities at both extremes, zero and mid values; varied stalls");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
